// ----- hdl/biou_pkg.sv -----
// ----------------------------------------------------------------------------
// biou_pkg
// Shared constants and types of the box IoU greedy matcher.
// ----------------------------------------------------------------------------
package biou_pkg;

	localparam int MAX_TRUTH = 64;
	localparam int IDX_W     = $clog2(MAX_TRUTH);
	localparam int CNT_W     = $clog2(MAX_TRUTH + 1);
	localparam int THR_W     = 17;
	localparam int ID_W      = 32;
	localparam int COORD_W   = 16;
	localparam int Q_W       = 17;
	localparam int REM_W     = 35;
	localparam int STEP_W    = 5;
	localparam logic [THR_W-1:0] ONE_FIX = 17'd65536;
	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_MATCH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_OV,
		ST_MUL,
		ST_UNI,
		ST_DIV,
		ST_CMP,
		ST_FIN
	} state_t;

	// one stored ground-truth entry
	typedef struct packed {
		logic               ign;
		logic               crowd;
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] h;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} entry_t;

endpackage

// ----- hdl/box_iou_greedy_matcher_top.sv -----
// ----------------------------------------------------------------------------
// box_iou_greedy_matcher_top
// Greedy IoU matching of detections against a stored ground-truth set.
// ----------------------------------------------------------------------------
// Clear, load and unused-operation beats strobe their result in the cycle
// after start. A match beat scans the stored boxes one at a time through an
// entry memory and one shared bit-serial divider: a skipped box passes read
// and overlap, a box with no overlap or no union passes read, overlap,
// multiply, union and compare, a scored box adds 17 divide steps between
// union and compare, and a finish step ends the scan of up to 64 boxes. busy
// stays high for the whole scan. done is high for the single strobe cycle;
// the results stay on the ports until the next accepted start; the receiver
// cannot stall them and must take each beat when done is high.
module box_iou_greedy_matcher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] box_x,
	input  logic [15:0] box_y,
	input  logic [15:0] box_w,
	input  logic [15:0] box_h,
	input  logic        crowd_box,
	input  logic        is_ignored,
	input  logic [31:0] label_id,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	output logic        done,
	output logic        status,
	output logic        matched,
	output logic [5:0]  match_index,
	output logic [31:0] match_id,
	output logic        match_ignored
);

	biou_pkg::state_t state_q, state_nx;

	logic [biou_pkg::THR_W-1:0]   thr_q;
	logic [biou_pkg::CNT_W-1:0]   cnt_q;
	logic [biou_pkg::CNT_W-1:0]   idx_q;
	logic [biou_pkg::MAX_TRUTH-1:0] taken_q;
	biou_pkg::entry_t             mem [biou_pkg::MAX_TRUTH];
	biou_pkg::entry_t             rd_q;
	logic [biou_pkg::COORD_W-1:0] dx_q, dy_q, dw_q, dh_q;
	logic [16:0]                  ow_q, oh_q;
	logic [33:0]                  inter_q;
	logic [31:0]                  ag_q, ad_q;
	logic [biou_pkg::REM_W-1:0]   rem_q;
	logic [33:0]                  div_q;
	logic [biou_pkg::Q_W-1:0]     q_q;
	logic [biou_pkg::STEP_W-1:0]  step_q;
	logic [biou_pkg::Q_W-1:0]     bar_q;
	logic                         found_q;
	logic [biou_pkg::IDX_W-1:0]   best_q;
	logic [31:0]                  best_id_q;
	logic                         best_ign_q;

	logic accept;
	logic [biou_pkg::IDX_W-1:0] addr;
	logic [16:0] gx_e, gy_e, dx_e, dy_e;
	logic [16:0] lo_x, lo_y, hi_x, hi_y;
	logic [33:0] uni;
	logic        skip, stop, ge;
	logic [biou_pkg::REM_W-1:0] rem_sub;

	assign accept = start && !busy;
	assign busy   = (state_q != biou_pkg::ST_IDLE);
	assign addr   = idx_q[biou_pkg::IDX_W-1:0];

	// overlap edges
	always_comb begin
		gx_e = {1'b0, rd_q.x} + {1'b0, rd_q.w};
		gy_e = {1'b0, rd_q.y} + {1'b0, rd_q.h};
		dx_e = {1'b0, dx_q} + {1'b0, dw_q};
		dy_e = {1'b0, dy_q} + {1'b0, dh_q};
		lo_x = (rd_q.x > dx_q) ? {1'b0, rd_q.x} : {1'b0, dx_q};
		lo_y = (rd_q.y > dy_q) ? {1'b0, rd_q.y} : {1'b0, dy_q};
		hi_x = (gx_e < dx_e) ? gx_e : dx_e;
		hi_y = (gy_e < dy_e) ? gy_e : dy_e;
		uni  = rd_q.crowd ? {2'b0, ad_q}
			: ({2'b0, ag_q} + {2'b0, ad_q} - inter_q);
		skip = taken_q[addr] && !rd_q.crowd;
		stop = found_q && !best_ign_q && rd_q.ign;
		ge   = (rem_q >= {1'b0, div_q});
		rem_sub = ge ? (rem_q - {1'b0, div_q}) : rem_q;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			biou_pkg::ST_IDLE: begin
				if (accept && operation == biou_pkg::OP_MATCH)
					state_nx = biou_pkg::ST_RD;
			end
			biou_pkg::ST_RD: begin
				state_nx = (idx_q >= cnt_q) ? biou_pkg::ST_FIN : biou_pkg::ST_OV;
			end
			biou_pkg::ST_OV: begin
				if (skip)
					state_nx = biou_pkg::ST_RD;
				else if (stop)
					state_nx = biou_pkg::ST_FIN;
				else
					state_nx = biou_pkg::ST_MUL;
			end
			biou_pkg::ST_MUL: state_nx = biou_pkg::ST_UNI;
			biou_pkg::ST_UNI: begin
				state_nx = (inter_q == '0 || uni == '0) ? biou_pkg::ST_CMP
					: biou_pkg::ST_DIV;
			end
			biou_pkg::ST_DIV: begin
				if (step_q == biou_pkg::STEP_W'(biou_pkg::Q_W - 1))
					state_nx = biou_pkg::ST_CMP;
			end
			biou_pkg::ST_CMP: state_nx = biou_pkg::ST_RD;
			biou_pkg::ST_FIN: state_nx = biou_pkg::ST_IDLE;
			default: state_nx = biou_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= biou_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	// entry memory: write on load, registered read at the scan index
	always_ff @(posedge clk) begin
		if (accept && operation == biou_pkg::OP_LOAD && cnt_q < biou_pkg::CNT_W'(biou_pkg::MAX_TRUTH))
			mem[cnt_q[biou_pkg::IDX_W-1:0]] <= '{ign: is_ignored, crowd: crowd_box,
				id: label_id, h: box_h, w: box_w, y: box_y, x: box_x};
		rd_q <= mem[addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= biou_pkg::THR_RESET;
			cnt_q         <= '0;
			idx_q         <= '0;
			taken_q       <= '0;
			found_q       <= 1'b0;
			done          <= 1'b0;
			status        <= 1'b0;
			matched       <= 1'b0;
			match_index   <= '0;
			match_id      <= '0;
			match_ignored <= 1'b0;
		end else begin
			// one-cycle strobe: immediate beats, or the end of a scan
			done <= (accept && operation != biou_pkg::OP_MATCH)
				|| (state_q == biou_pkg::ST_FIN);
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (accept) begin
				status        <= 1'b0;
				matched       <= 1'b0;
				match_index   <= '0;
				match_id      <= '0;
				match_ignored <= 1'b0;
				idx_q         <= '0;
				found_q       <= 1'b0;
				case (operation)
					biou_pkg::OP_CLEAR: begin
						cnt_q   <= '0;
						taken_q <= '0;
					end
					biou_pkg::OP_LOAD: begin
						if (cnt_q < biou_pkg::CNT_W'(biou_pkg::MAX_TRUTH)) begin
							taken_q[cnt_q[biou_pkg::IDX_W-1:0]] <= 1'b0;
							cnt_q <= cnt_q + 1'b1;
						end else begin
							status <= 1'b1;
						end
					end
					biou_pkg::OP_MATCH: ;
					default: ;
				endcase
			end
			case (state_q)
				biou_pkg::ST_OV: begin
					if (skip)
						idx_q <= idx_q + 1'b1;
				end
				biou_pkg::ST_CMP: begin
					if (q_q >= bar_q)
						found_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				biou_pkg::ST_FIN: begin
					if (found_q)
						taken_q[best_q] <= 1'b1;
					matched       <= found_q;
					match_index   <= found_q ? best_q : '0;
					match_id      <= found_q ? best_id_q : '0;
					match_ignored <= found_q && best_ign_q;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q  <= box_x;
			dy_q  <= box_y;
			dw_q  <= box_w;
			dh_q  <= box_h;
			bar_q <= (thr_q > biou_pkg::ONE_FIX) ? biou_pkg::ONE_FIX : thr_q;
			best_q     <= '0;
			best_id_q  <= '0;
			best_ign_q <= 1'b0;
		end
		case (state_q)
			biou_pkg::ST_OV: begin
				ow_q <= (hi_x > lo_x) ? (hi_x - lo_x) : '0;
				oh_q <= (hi_y > lo_y) ? (hi_y - lo_y) : '0;
			end
			biou_pkg::ST_MUL: begin
				inter_q <= ow_q * oh_q;
				ag_q    <= rd_q.w * rd_q.h;
				ad_q    <= dw_q * dh_q;
			end
			biou_pkg::ST_UNI: begin
				rem_q  <= {1'b0, inter_q};
				div_q  <= uni;
				q_q    <= '0;
				step_q <= '0;
			end
			biou_pkg::ST_DIV: begin
				q_q    <= {q_q[biou_pkg::Q_W-2:0], ge};
				rem_q  <= {rem_sub[biou_pkg::REM_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
			end
			biou_pkg::ST_CMP: begin
				if (q_q >= bar_q) begin
					bar_q      <= q_q;
					best_q     <= addr;
					best_id_q  <= rd_q.id;
					best_ign_q <= rd_q.ign;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> idx_q <= cnt_q)
		else $error("scan index past fill count");
	a_match_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done && matched) |-> ({1'b0, match_index} < cnt_q))
		else $error("match outside stored set");
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !matched)
		else $error("drop status with a match");
	a_match_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(done && matched) |-> taken_q[match_index])
		else $error("matched box not marked taken");

endmodule
